/* rtl/dtrf_pkg.sv */
// Shared types and constants for the dithered tile rectangle fill block.
// No dependencies; used by the front end, the pass queue and the back end.
`default_nettype none
package dtrf_pkg;

	localparam int CELLS_W  = 40;
	localparam int ADDR_W   = 16;
	localparam int CALC_W   = 17;
	localparam int EDGE_W   = 12;
	localparam int COLOURS  = 16;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_DRAW = 1'b1;

	localparam logic [1:0] CFG_LEFT_X       = 2'd0;
	localparam logic [1:0] CFG_RIGHT_END_X  = 2'd1;
	localparam logic [1:0] CFG_TOP_Y        = 2'd2;
	localparam logic [1:0] CFG_BOTTOM_END_Y = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [7:0]         clip;
		logic [CELLS_W-1:0] trow;
		logic [COLOURS-1:0] present;
	} pass_job_t;

endpackage
`default_nettype wire

/* rtl/dtrf_front.sv */
// Front end: config registers, tile row store, rectangle and clip classification.
// Depends on dtrf_pkg; feeds dtrf_queue with one job per drawable byte.
`default_nettype none
module dtrf_front #(
	parameter int ROW_BYTES   = 80,
	parameter int SCREEN_ROWS = 480
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [9:0]          cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                func,
	input  wire logic [8:0]          row_y,
	input  wire logic [6:0]          byte_col,
	input  wire logic [dtrf_pkg::CELLS_W-1:0] cells,
	input  wire logic                q_full,
	output logic                     q_push,
	output dtrf_pkg::pass_job_t      q_job
);

	localparam int XMAX = ROW_BYTES * 8;
	localparam int EW   = dtrf_pkg::EDGE_W;
	localparam int CW   = dtrf_pkg::CALC_W;

	logic [9:0] left_q;
	logic [9:0] right_q;
	logic [8:0] top_q;
	logic [8:0] bottom_q;
	logic [dtrf_pkg::CELLS_W-1:0] tile_q [8];

	logic          accept;
	logic [EW-1:0] xr, xr_m1, yb;
	logic [7:0]    sb, eb, col8;
	logic          in_rect;
	logic [7:0]    clip;
	logic [CW-1:0] addr_full;
	logic [dtrf_pkg::CELLS_W-1:0] trow;
	logic [dtrf_pkg::COLOURS-1:0] present;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= 10'd0;
			right_q  <= 10'd640;
			top_q    <= 9'd0;
			bottom_q <= 9'd480;
		end else if (cfg_we) begin
			case (cfg_index)
				dtrf_pkg::CFG_LEFT_X:       left_q   <= cfg_wdata;
				dtrf_pkg::CFG_RIGHT_END_X:  right_q  <= cfg_wdata;
				dtrf_pkg::CFG_TOP_Y:        top_q    <= cfg_wdata[8:0];
				dtrf_pkg::CFG_BOTTOM_END_Y: bottom_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept && func == dtrf_pkg::FUNC_LOAD)
			tile_q[row_y[2:0]] <= cells;
	end

	always_comb begin
		xr    = (EW'(right_q) > EW'(XMAX)) ? EW'(XMAX) : EW'(right_q);
		yb    = (EW'(bottom_q) > EW'(SCREEN_ROWS)) ? EW'(SCREEN_ROWS) : EW'(bottom_q);
		xr_m1 = xr - EW'(1);
		sb    = {1'b0, left_q[9:3]};
		eb    = xr_m1[10:3];
		col8  = {1'b0, byte_col};
		in_rect = (EW'(left_q) < xr) && (EW'(top_q) < yb)
			&& (row_y >= top_q) && (EW'(row_y) < yb)
			&& (col8 >= sb) && (col8 <= eb);
		clip = 8'hFF;
		if (col8 == sb)
			clip = clip & (8'hFF >> left_q[2:0]);
		if (col8 == eb)
			clip = clip & (8'hFF << (3'd7 - xr_m1[2:0]));
		addr_full = CW'(row_y) * CW'(ROW_BYTES) + CW'(byte_col);
		trow = tile_q[row_y[2:0]];
		present = '0;
		for (int c = 0; c < dtrf_pkg::COLOURS; c++) begin
			for (int k = 0; k < 8; k++) begin
				if (trow[5*k +: 5] == 5'(c) && clip[7-k])
					present[c] = 1'b1;
			end
		end
	end

	assign q_push = accept && func == dtrf_pkg::FUNC_DRAW && in_rect && (present != '0);

	always_comb begin
		q_job.addr    = addr_full[dtrf_pkg::ADDR_W-1:0];
		q_job.clip    = clip;
		q_job.trow    = trow;
		q_job.present = present;
	end

endmodule
`default_nettype wire

/* rtl/dtrf_queue.sv */
// Two-entry job queue between the classifying front end and the pass walker.
// Depends on dtrf_pkg for the job type.
`default_nettype none
module dtrf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire dtrf_pkg::pass_job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                valid,
	output dtrf_pkg::pass_job_t head
);

	dtrf_pkg::pass_job_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full  = count_q == 2'd2;
	assign valid = count_q != 2'd0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop && valid)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop && valid})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("job pushed into full queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");

endmodule
`default_nettype wire

/* rtl/dtrf_back.sv */
// Back end: walks a job's colours, one pass per cycle unless stalled, to the output register.
// Depends on dtrf_pkg; pops jobs from dtrf_queue.
`default_nettype none
module dtrf_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire dtrf_pkg::pass_job_t q_head,
	output logic                q_pop,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [31:0]         m_tdata,
	output logic                m_tlast
);

	localparam int NC = dtrf_pkg::COLOURS;

	logic [dtrf_pkg::ADDR_W-1:0]  addr_q;
	logic [7:0]                   clip_q;
	logic [dtrf_pkg::CELLS_W-1:0] trow_q;
	logic [NC-1:0]                pend_q;

	logic          valid_q, last_q;
	logic [dtrf_pkg::ADDR_W-1:0] out_addr_q;
	logic [3:0]    out_colour_q;
	logic [7:0]    out_mask_q;

	logic          out_free, emit, last_c;
	logic [NC-1:0] low_hot, pend_rest;
	logic [3:0]    colour_c;
	logic [7:0]    mask_c;

	always_comb begin
		low_hot   = pend_q & (~pend_q + NC'(1));
		pend_rest = pend_q & ~low_hot;
		colour_c  = '0;
		for (int i = 0; i < NC; i++) begin
			if (low_hot[i])
				colour_c = colour_c | 4'(i);
		end
		for (int k = 0; k < 8; k++)
			mask_c[7-k] = (trow_q[5*k +: 5] == {1'b0, colour_c}) && clip_q[7-k];
		last_c   = pend_rest == '0;
		out_free = !valid_q || m_tready;
		emit     = out_free && (pend_q != '0);
		q_pop    = q_valid && ((pend_q == '0) || (emit && last_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (q_pop)
				pend_q <= q_head.present;
			else if (emit)
				pend_q <= pend_rest;
			if (out_free)
				valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			addr_q <= q_head.addr;
			clip_q <= q_head.clip;
			trow_q <= q_head.trow;
		end
		if (emit) begin
			out_addr_q   <= addr_q;
			out_colour_q <= colour_c;
			out_mask_q   <= mask_c;
			last_q       <= last_c;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {4'b0, out_mask_q, out_colour_q, out_addr_q};
	assign m_tlast  = last_q;

	a_mask_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> out_mask_q != 8'd0) else $error("empty pass emitted");
	a_passes_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && m_tready && !last_q) |=> valid_q)
		else $error("gap inside a byte's passes");

endmodule
`default_nettype wire

/* rtl/dither_tile_rect_fill_passes_top.sv */
// Top level of the dithered tile rectangle fill; ties front end, job queue and back end.
// Depends on dtrf_pkg, dtrf_front, dtrf_queue and dtrf_back.
//
// A load transaction stores one 8-cell tile row. A draw transaction is classified on
// acceptance (rectangle test, clip masks, address, colours present) and, if anything
// is to be written, queued as one job; the back end then gives one pass per colour
// present (1 to 8 per queued job), one pass per cycle while m_tready does not stall it.
// Sustained rate is set by the back end's colour walker at one pass per cycle; the
// two-entry queue lets the input keep accepting one transaction a cycle while it has room.
`default_nettype none
module dither_tile_rect_fill_passes_top #(
	parameter int ROW_BYTES   = 80,
	parameter int SCREEN_ROWS = 480
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // row_y[8:0], byte_col[15:9], cells[55:16]
	input  wire logic        s_tuser,   // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // vram_address[15:0], colour[19:16], bit_mask[27:20]
	output logic             m_tlast    // last_pass
);

	logic                q_push, q_full, q_pop, q_valid;
	dtrf_pkg::pass_job_t push_job, head_job;

	dtrf_front #(
		.ROW_BYTES   (ROW_BYTES),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.func      (s_tuser),
		.row_y     (s_tdata[8:0]),
		.byte_col  (s_tdata[15:9]),
		.cells     (s_tdata[55:16]),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	dtrf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head_job)
	);

	dtrf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (head_job),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
